// ----- rtl/zisp_pkg.sv -----
// Package: shared types, widths and codes for the zero-island peak statistics block.
`default_nettype none

package zisp_pkg;

    localparam int IDX_W      = 16;
    localparam int FIELD_W    = 24;
    localparam int TOTAL_W    = 40;
    localparam int WACC_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_MEANS  = 3;
    localparam int SEL_W      = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEFAULT_MAX_SAMPLES = 65536;
    localparam int DEFAULT_SAMPLE_BITS = 24;

    localparam logic [CFG_IDX_W-1:0] REG_USE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RI_THRESHOLD  = 1'd1;

    localparam logic [SEL_W-1:0] MEAN_RH = 2'd0;
    localparam logic [SEL_W-1:0] MEAN_MW = 2'd1;
    localparam logic [SEL_W-1:0] MEAN_D  = 2'd2;

    typedef struct packed {
        logic               use_threshold;
        logic [FIELD_W-1:0] ri_threshold;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_OPEN,
        OP_ADD,
        OP_CLOSE
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_CHECK,
        BK_ITER,
        BK_HOLD
    } back_state_t;

    typedef struct packed {
        logic [IDX_W-1:0]   start_index;
        logic [IDX_W-1:0]   end_index;
        logic [IDX_W-1:0]   peak_number;
        logic [TOTAL_W-1:0] ri_total;
        logic [WACC_W-1:0]  rh_sum;
        logic [WACC_W-1:0]  mw_sum;
        logic [WACC_W-1:0]  d_sum;
        logic [IDX_W-1:0]   top_index;
        logic [FIELD_W-1:0] top_rh;
        logic [FIELD_W-1:0] top_mw;
        logic [FIELD_W-1:0] top_diffusion;
    } peak_rec_t;

endpackage

`default_nettype wire

// ----- rtl/zisp_if.sv -----
// Interfaces: sample request channel and peak result channel.
`default_nettype none

interface zisp_sample_if
    import zisp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] ri;
    logic [FIELD_W-1:0] mw;
    logic [FIELD_W-1:0] rh;
    logic [FIELD_W-1:0] diffusion;
    logic               stream_end;

    modport source (output valid, ri, mw, rh, diffusion, stream_end, input ready);
    modport sink   (input valid, ri, mw, rh, diffusion, stream_end, output ready);
endinterface

interface zisp_result_if
    import zisp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   start_index;
    logic [IDX_W-1:0]   end_index;
    logic [IDX_W-1:0]   peak_number;
    logic [TOTAL_W-1:0] ri_total;
    logic [FIELD_W-1:0] mean_rh;
    logic [FIELD_W-1:0] mean_mw;
    logic [FIELD_W-1:0] mean_diffusion;
    logic [IDX_W-1:0]   top_index;
    logic [FIELD_W-1:0] top_rh;
    logic [FIELD_W-1:0] top_mw;
    logic [FIELD_W-1:0] top_diffusion;
    logic               zero_weight;

    modport source (output valid, start_index, end_index, peak_number, ri_total, mean_rh,
                    mean_mw, mean_diffusion, top_index, top_rh, top_mw, top_diffusion,
                    zero_weight, input ready);
    modport sink   (input valid, start_index, end_index, peak_number, ri_total, mean_rh,
                    mean_mw, mean_diffusion, top_index, top_rh, top_mw, top_diffusion,
                    zero_weight, output ready);
endinterface

`default_nettype wire

// ----- rtl/zisp_front.sv -----
// Front end: classifies samples, tracks peaks, accumulates sums and the RI maximum.
`default_nettype none

module zisp_front
    import zisp_pkg::*;
#(
    parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    zisp_sample_if.sink     samples,
    output logic            push_valid,
    output peak_rec_t       push_rec,
    input  wire logic       push_ready
);

    localparam int SW = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int PW = 2 * SW;
    localparam int IDX_MAX = (1 << IDX_W) - 1;
    localparam int CAP_I = (MAX_SAMPLES - 1 > IDX_MAX) ? IDX_MAX : MAX_SAMPLES - 1;
    localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(CAP_I);

    // classify stage
    logic [IDX_W-1:0] sample_count_reg, sample_count_next;
    logic [IDX_W-1:0] last_index_reg, last_index_next;
    logic [IDX_W-1:0] open_start_reg, open_start_next;
    logic [IDX_W-1:0] peak_cnt_reg, peak_cnt_next;
    logic             prev_zero_reg, prev_zero_next;
    logic             in_peak_reg, in_peak_next;

    logic [SW-1:0] ri_s, mw_raw, mw_s, rh_s, d_s;
    logic [PW-1:0] prod_rh, prod_mw, prod_d;
    logic          below, zero, do_close, do_open, do_add, has_op, a_fire;
    op_t           a_op;

    // accumulate stage
    logic             b_valid_reg, b_valid_next;
    op_t              b_op_reg;
    logic [IDX_W-1:0] b_idx_reg, b_start_reg, b_last_reg, b_num_reg;
    logic [SW-1:0]    b_ri_reg, b_rh_reg, b_mw_reg, b_d_reg;
    logic [PW-1:0]    b_prh_reg, b_pmw_reg, b_pd_reg;
    logic             b_adv;

    logic [TOTAL_W-1:0] ri_acc_reg, ri_acc_next;
    logic [WACC_W-1:0]  rh_acc_reg, rh_acc_next;
    logic [WACC_W-1:0]  mw_acc_reg, mw_acc_next;
    logic [WACC_W-1:0]  d_acc_reg, d_acc_next;
    logic [SW-1:0]      max_ri_reg, max_ri_next;
    logic [IDX_W-1:0]   max_pos_reg, max_pos_next;
    logic [SW-1:0]      max_rh_reg, max_rh_next;
    logic [SW-1:0]      max_mw_reg, max_mw_next;
    logic [SW-1:0]      max_d_reg, max_d_next;

    logic [TOTAL_W:0] ri_sum;
    logic [WACC_W:0]  rh_sum, mw_sum, d_sum;

    assign ri_s   = samples.ri[SW-1:0];
    assign mw_raw = samples.mw[SW-1:0];
    assign rh_s   = samples.rh[SW-1:0];
    assign d_s    = samples.diffusion[SW-1:0];

    assign below = cfg.use_threshold && (FIELD_W'(ri_s) < cfg.ri_threshold);
    assign mw_s  = below ? '0 : mw_raw;
    assign zero  = (mw_s == '0);

    assign do_close = in_peak_reg && zero;
    assign do_open  = !in_peak_reg && !zero && prev_zero_reg;
    assign do_add   = in_peak_reg && !zero;
    assign has_op   = do_close || do_open || do_add;

    always_comb
    begin
        a_op = OP_ADD;
        if (do_close)
        begin
            a_op = OP_CLOSE;
        end
        else if (do_open)
        begin
            a_op = OP_OPEN;
        end
    end

    assign prod_rh = rh_s * ri_s;
    assign prod_mw = mw_s * ri_s;
    assign prod_d  = d_s * ri_s;

    assign b_adv         = b_valid_reg && ((b_op_reg != OP_CLOSE) || push_ready);
    assign samples.ready = !b_valid_reg || b_adv;
    assign a_fire        = samples.valid && samples.ready;

    always_comb
    begin
        sample_count_next = sample_count_reg;
        last_index_next   = last_index_reg;
        open_start_next   = open_start_reg;
        peak_cnt_next     = peak_cnt_reg;
        prev_zero_next    = prev_zero_reg;
        in_peak_next      = in_peak_reg;
        if (a_fire)
        begin
            if (samples.stream_end)
            begin
                sample_count_next = '0;
                last_index_next   = '0;
                open_start_next   = '0;
                peak_cnt_next     = '0;
                prev_zero_next    = 1'b0;
                in_peak_next      = 1'b0;
            end
            else
            begin
                if (sample_count_reg < IDX_CAP)
                begin
                    sample_count_next = sample_count_reg + 1'b1;
                end
                last_index_next = sample_count_reg;
                prev_zero_next  = zero;
                in_peak_next    = do_open || do_add;
                if (do_open)
                begin
                    open_start_next = sample_count_reg;
                end
                if (do_close)
                begin
                    peak_cnt_next = peak_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            last_index_reg   <= '0;
            open_start_reg   <= '0;
            peak_cnt_reg     <= '0;
            prev_zero_reg    <= 1'b0;
            in_peak_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            last_index_reg   <= last_index_next;
            open_start_reg   <= open_start_next;
            peak_cnt_reg     <= peak_cnt_next;
            prev_zero_reg    <= prev_zero_next;
            in_peak_reg      <= in_peak_next;
            b_valid_reg      <= b_valid_next;
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (a_fire)
        begin
            b_valid_next = has_op;
        end
        else if (b_adv)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_op_reg    <= a_op;
            b_idx_reg   <= sample_count_reg;
            b_start_reg <= open_start_reg;
            b_last_reg  <= last_index_reg;
            b_num_reg   <= peak_cnt_reg;
            b_ri_reg    <= ri_s;
            b_rh_reg    <= rh_s;
            b_mw_reg    <= mw_s;
            b_d_reg     <= d_s;
            b_prh_reg   <= prod_rh;
            b_pmw_reg   <= prod_mw;
            b_pd_reg    <= prod_d;
        end
    end

    assign ri_sum = {1'b0, ri_acc_reg} + (TOTAL_W + 1)'(b_ri_reg);
    assign rh_sum = {1'b0, rh_acc_reg} + (WACC_W + 1)'(b_prh_reg);
    assign mw_sum = {1'b0, mw_acc_reg} + (WACC_W + 1)'(b_pmw_reg);
    assign d_sum  = {1'b0, d_acc_reg} + (WACC_W + 1)'(b_pd_reg);

    always_comb
    begin
        ri_acc_next  = ri_acc_reg;
        rh_acc_next  = rh_acc_reg;
        mw_acc_next  = mw_acc_reg;
        d_acc_next   = d_acc_reg;
        max_ri_next  = max_ri_reg;
        max_pos_next = max_pos_reg;
        max_rh_next  = max_rh_reg;
        max_mw_next  = max_mw_reg;
        max_d_next   = max_d_reg;
        if (b_adv)
        begin
            case (b_op_reg)
                OP_OPEN:
                begin
                    ri_acc_next  = TOTAL_W'(b_ri_reg);
                    rh_acc_next  = WACC_W'(b_prh_reg);
                    mw_acc_next  = WACC_W'(b_pmw_reg);
                    d_acc_next   = WACC_W'(b_pd_reg);
                    max_ri_next  = b_ri_reg;
                    max_pos_next = b_idx_reg;
                    max_rh_next  = b_rh_reg;
                    max_mw_next  = b_mw_reg;
                    max_d_next   = b_d_reg;
                end
                OP_ADD:
                begin
                    ri_acc_next = ri_sum[TOTAL_W] ? '1 : ri_sum[TOTAL_W-1:0];
                    rh_acc_next = rh_sum[WACC_W] ? '1 : rh_sum[WACC_W-1:0];
                    mw_acc_next = mw_sum[WACC_W] ? '1 : mw_sum[WACC_W-1:0];
                    d_acc_next  = d_sum[WACC_W] ? '1 : d_sum[WACC_W-1:0];
                    if (b_ri_reg > max_ri_reg)
                    begin
                        max_ri_next  = b_ri_reg;
                        max_pos_next = b_idx_reg;
                        max_rh_next  = b_rh_reg;
                        max_mw_next  = b_mw_reg;
                        max_d_next   = b_d_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ri_acc_reg  <= ri_acc_next;
        rh_acc_reg  <= rh_acc_next;
        mw_acc_reg  <= mw_acc_next;
        d_acc_reg   <= d_acc_next;
        max_ri_reg  <= max_ri_next;
        max_pos_reg <= max_pos_next;
        max_rh_reg  <= max_rh_next;
        max_mw_reg  <= max_mw_next;
        max_d_reg   <= max_d_next;
    end

    assign push_valid = b_valid_reg && (b_op_reg == OP_CLOSE);

    always_comb
    begin
        push_rec.start_index   = b_start_reg;
        push_rec.end_index     = b_last_reg;
        push_rec.peak_number   = b_num_reg;
        push_rec.ri_total      = ri_acc_reg;
        push_rec.rh_sum        = rh_acc_reg;
        push_rec.mw_sum        = mw_acc_reg;
        push_rec.d_sum         = d_acc_reg;
        push_rec.top_index     = max_pos_reg;
        push_rec.top_rh        = FIELD_W'(max_rh_reg);
        push_rec.top_mw        = FIELD_W'(max_mw_reg);
        push_rec.top_diffusion = FIELD_W'(max_d_reg);
    end

endmodule

`default_nettype wire

// ----- rtl/zisp_fifo.sv -----
// Queue of closed-peak records between front end and divider.
`default_nettype none

module zisp_fifo
    import zisp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire peak_rec_t push_data,
    output logic           full,
    input  wire logic      pop,
    output peak_rec_t      rdata,
    output logic           empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    peak_rec_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    peak_rec_t        rdata_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = rdata_reg;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (do_pop)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/zisp_back.sv -----
// Back end: shared radix-2 divider for the three weighted means, and the result register.
`default_nettype none

module zisp_back
    import zisp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    output logic            q_pop,
    input  wire peak_rec_t  q_data,
    zisp_result_if.source   results
);

    localparam int CNT_W = $clog2(FIELD_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FIELD_W - 1);
    localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(NUM_MEANS - 1);

    back_state_t state_reg, state_next;

    peak_rec_t          rec_reg, rec_next;
    logic [SEL_W-1:0]   sel_reg, sel_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [FIELD_W-1:0] quot_reg, quot_next;
    logic [FIELD_W-1:0] mean_reg [NUM_MEANS];
    logic [FIELD_W-1:0] mean_val;
    logic               mean_we;

    logic               out_valid_reg, out_valid_next;
    peak_rec_t          out_rec_reg;
    logic [FIELD_W-1:0] out_mean_reg [NUM_MEANS];
    logic               out_zw_reg;

    logic [WACC_W-1:0]  num;
    logic [FIELD_W-1:0] num_low;
    logic [TOTAL_W:0]   r2, r2_sub;
    logic               ge, den_zero, overflow, out_load, mean_done;

    always_comb
    begin
        case (sel_reg)
            MEAN_RH: num = rec_reg.rh_sum;
            MEAN_MW: num = rec_reg.mw_sum;
            default: num = rec_reg.d_sum;
        endcase
    end

    assign num_low  = num[FIELD_W-1:0];
    assign den_zero = (rec_reg.ri_total == '0);
    assign overflow = (num >= {rec_reg.ri_total, {FIELD_W{1'b0}}});
    assign r2       = {rem_reg, num_low[cnt_reg]};
    assign ge       = (r2 >= {1'b0, rec_reg.ri_total});
    assign r2_sub   = r2 - {1'b0, rec_reg.ri_total};
    assign out_load = (state_reg == BK_HOLD) && (!out_valid_reg || results.ready);

    always_comb
    begin
        mean_done = 1'b0;
        if ((state_reg == BK_CHECK) && (den_zero || overflow))
        begin
            mean_done = 1'b1;
        end
        if ((state_reg == BK_ITER) && (cnt_reg == '0))
        begin
            mean_done = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK, BK_ITER:
            begin
                if (mean_done)
                begin
                    state_next = (sel_reg == LAST_SEL) ? BK_HOLD : BK_CHECK;
                end
                else
                begin
                    state_next = BK_ITER;
                end
            end
            BK_HOLD:
            begin
                if (out_load)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop     = 1'b0;
        rec_next  = rec_reg;
        sel_next  = sel_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        mean_we   = 1'b0;
        mean_val  = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            BK_LOAD:
            begin
                rec_next = q_data;
                sel_next = MEAN_RH;
            end
            BK_CHECK:
            begin
                cnt_next  = LAST_BIT;
                rem_next  = num[WACC_W-1:FIELD_W];
                quot_next = '0;
                if (den_zero)
                begin
                    mean_we = 1'b1;
                end
                else if (overflow)
                begin
                    mean_we  = 1'b1;
                    mean_val = '1;
                end
            end
            BK_ITER:
            begin
                rem_next  = ge ? r2_sub[TOTAL_W-1:0] : r2[TOTAL_W-1:0];
                quot_next = {quot_reg[FIELD_W-2:0], ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    mean_we  = 1'b1;
                    mean_val = quot_next;
                end
            end
            BK_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
        if (mean_done && (sel_reg != LAST_SEL))
        begin
            sel_next = sel_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        sel_reg  <= sel_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (mean_we)
        begin
            mean_reg[sel_reg] <= mean_val;
        end
        if (out_load)
        begin
            out_rec_reg  <= rec_reg;
            out_mean_reg <= mean_reg;
            out_zw_reg   <= den_zero;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.start_index    = out_rec_reg.start_index;
    assign results.end_index      = out_rec_reg.end_index;
    assign results.peak_number    = out_rec_reg.peak_number;
    assign results.ri_total       = out_rec_reg.ri_total;
    assign results.mean_rh        = out_mean_reg[MEAN_RH];
    assign results.mean_mw        = out_mean_reg[MEAN_MW];
    assign results.mean_diffusion = out_mean_reg[MEAN_D];
    assign results.top_index      = out_rec_reg.top_index;
    assign results.top_rh         = out_rec_reg.top_rh;
    assign results.top_mw         = out_rec_reg.top_mw;
    assign results.top_diffusion  = out_rec_reg.top_diffusion;
    assign results.zero_weight    = out_zw_reg;

endmodule

`default_nettype wire

// ----- rtl/zero_island_peak_stats_core.sv -----
// Top level: zero-island peak statistics core.
//
// samples: one detector request (ri, mw, rh, diffusion, stream_end) per valid/ready
//   handshake. Up to one sample per cycle; ready drops only while a closed peak
//   waits for room in the 4-entry record queue.
// results: one request per closed peak: indices, peak number, RI sum, RI-weighted
//   means, values at the first RI maximum, zero-weight flag.
// cfg_we/cfg_index/cfg_data: register writes (use_threshold, ri_threshold); the user
//   must write them only while the core is idle, the core does not enforce it.
// Path from the closing sample to its result: the front end and queue, a load of
//   the divider, the three restoring divisions in turn (one quotient bit per cycle),
//   then the output register.
// Throughput: samples 1/cycle while ready is high; one peak at a time in the divider.
//   Bursts of short peaks are absorbed by the queue, then the sample side stalls.
// Reset: peak tracking and FSM state cleared, use_threshold = 1, ri_threshold = 0.
// Output stall: the output register holds its request; the divider finishes the
//   next peak and waits, the queue fills, then samples.ready falls.
`default_nettype none

module zero_island_peak_stats_core
    import zisp_pkg::*;
#(
    parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    zisp_sample_if.sink                samples,
    zisp_result_if.source              results
);

    cfg_t      cfg_reg, cfg_next;
    logic      push_valid, q_full, q_empty, q_pop;
    peak_rec_t push_rec, q_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_USE_THRESHOLD: cfg_next.use_threshold = cfg_data[0];
                REG_RI_THRESHOLD:  cfg_next.ri_threshold  = cfg_data[FIELD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_threshold <= 1'b1;
            cfg_reg.ri_threshold  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    zisp_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .samples    (samples),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (!q_full)
    );

    zisp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_data),
        .empty     (q_empty)
    );

    zisp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .results (results)
    );

endmodule

`default_nettype wire

// ----- rtl/zisp_checker.sv -----
// Port-level checker for the result channel, bound to the top level.
`default_nettype none

module zisp_checker
    import zisp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               valid,
    input wire logic               ready,
    input wire logic [IDX_W-1:0]   start_index,
    input wire logic [IDX_W-1:0]   end_index,
    input wire logic [IDX_W-1:0]   top_index,
    input wire logic [TOTAL_W-1:0] ri_total,
    input wire logic [FIELD_W-1:0] mean_rh,
    input wire logic [FIELD_W-1:0] mean_mw,
    input wire logic [FIELD_W-1:0] mean_diffusion,
    input wire logic               zero_weight
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(ri_total) && $stable(start_index) && $stable(mean_mw))
        else $error("result payload changed while stalled");

    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (zero_weight == (ri_total == '0)))
        else $error("zero_weight disagrees with ri_total");

    a_zero_means: assert property (@(posedge clk) disable iff (!rst_n)
        valid && zero_weight |-> (mean_rh == '0) && (mean_mw == '0) && (mean_diffusion == '0))
        else $error("nonzero mean with zero weight");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (start_index <= top_index) && (top_index <= end_index))
        else $error("peak indices out of order");

endmodule

bind zero_island_peak_stats_core zisp_checker u_zisp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (results.valid),
    .ready          (results.ready),
    .start_index    (results.start_index),
    .end_index      (results.end_index),
    .top_index      (results.top_index),
    .ri_total       (results.ri_total),
    .mean_rh        (results.mean_rh),
    .mean_mw        (results.mean_mw),
    .mean_diffusion (results.mean_diffusion),
    .zero_weight    (results.zero_weight)
);

`default_nettype wire
